// ===== rtl/modem_link_stream_parser_unit_assert.svh =====
// assertion macros for the modem link stream parser checker
`ifndef MODEM_LINK_STREAM_PARSER_UNIT_ASSERT_SVH
`define MODEM_LINK_STREAM_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MLSP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stream parser check failed");

// next-cycle implication, sampled on clk, off while in reset
`define MLSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stream parser check failed");

`endif

// ===== rtl/mlsp_pkg.sv =====
// shared types and constants for the modem link stream parser
package mlsp_pkg;

  // event codes
  localparam logic [3:0] EV_PAYLOAD = 4'd0;
  localparam logic [3:0] EV_MSGEND  = 4'd1;
  localparam logic [3:0] EV_ACK     = 4'd2;
  localparam logic [3:0] EV_NACK    = 4'd3;
  localparam logic [3:0] EV_RING    = 4'd4;
  localparam logic [3:0] EV_CONNECT = 4'd5;
  localparam logic [3:0] EV_NOCARR  = 4'd6;
  localparam logic [3:0] EV_UNKNOWN = 4'd7;
  localparam logic [3:0] EV_ERROR   = 4'd8;

  // largest two-digit sequence number
  localparam logic [6:0] SEQ_MAX = 7'd99;

  // configuration register indexes
  localparam logic CFG_MESSAGE_LIMIT = 1'b0;
  localparam logic CFG_STATUS_LIMIT  = 1'b1;

  localparam logic [11:0] MESSAGE_LIMIT_RST = 12'd2046;
  localparam logic [9:0]  STATUS_LIMIT_RST  = 10'd255;

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] data_byte;
    logic [6:0] seq_number;
    logic       link_connected;
  } mlsp_result_t;

endpackage

// ===== rtl/mlsp_core.sv =====
// per-byte frame parser: state registers and next-state / event logic
module mlsp_core import mlsp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  logic [7:0]   rx_byte,
  input  logic [11:0]  message_limit,
  input  logic [9:0]   status_limit,
  output logic         res_valid,
  output mlsp_result_t res
);

  localparam logic [2:0] CTX_IDLE     = 3'd0;
  localparam logic [2:0] CTX_MSG_SEQ  = 3'd1;
  localparam logic [2:0] CTX_ACK_SEQ  = 3'd2;
  localparam logic [2:0] CTX_NACK_SEQ = 3'd3;
  localparam logic [2:0] CTX_MSG_TEXT = 3'd4;
  localparam logic [2:0] CTX_MSG_ESC  = 3'd5;
  localparam logic [2:0] CTX_ACK_END  = 3'd6;
  localparam logic [2:0] CTX_NACK_END = 3'd7;

  localparam logic [1:0] PH_NONE   = 2'd0;
  localparam logic [1:0] PH_WANTLF = 2'd1;
  localparam logic [1:0] PH_TEXT   = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] KW_RING_TXT   [5]  = '{"R", "I", "N", "G", " "};
  localparam logic [7:0] KW_CONN_TXT   [8]  = '{"C", "O", "N", "N", "E", "C", "T", " "};
  localparam logic [7:0] KW_NOCARR_TXT [10] =
    '{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R"};
  localparam logic [9:0] KW_RING_LEN   = 10'd5;
  localparam logic [9:0] KW_CONN_LEN   = 10'd8;
  localparam logic [9:0] KW_NOCARR_LEN = 10'd10;

  logic [2:0]  ctx_r, ctx_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  digit_cnt_r, digit_cnt_nxt;
  logic [6:0]  seq_r, seq_nxt;
  logic [7:0]  hex_r, hex_nxt;
  logic [11:0] pay_cnt_r, pay_cnt_nxt;
  logic [9:0]  stat_pos_r, stat_pos_nxt;
  logic [2:0]  kw_flags_r, kw_flags_nxt;
  logic        link_r, link_nxt;

  logic        ev_valid;
  logic [3:0]  ev_code;
  logic [7:0]  ev_data;
  logic        pay_req;
  logic [7:0]  pay_byte;
  logic [1:0]  digit_inc;
  logic        is_digit;
  logic [6:0]  seq_calc;
  logic [4:0]  hex_dec;

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, b[3:0]};
    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit_inc = digit_cnt_r + 2'd1;
  // seq * 10 + digit, kept to 7 bits
  assign seq_calc  = {seq_r[3:0], 3'b000} + {seq_r[5:0], 1'b0} + {3'b000, rx_byte[3:0]};
  assign hex_dec   = hex_value(rx_byte);

  always_comb begin
    ctx_nxt       = ctx_r;
    phase_nxt     = phase_r;
    digit_cnt_nxt = digit_cnt_r;
    seq_nxt       = seq_r;
    hex_nxt       = hex_r;
    pay_cnt_nxt   = pay_cnt_r;
    stat_pos_nxt  = stat_pos_r;
    kw_flags_nxt  = kw_flags_r;
    link_nxt      = link_r;
    ev_valid      = 1'b0;
    ev_code       = EV_PAYLOAD;
    ev_data       = 8'd0;
    pay_req       = 1'b0;
    pay_byte      = rx_byte;

    if (phase_r != PH_NONE) begin
      // status frame has priority over the enclosing frame
      if (phase_r == PH_WANTLF) begin
        if (rx_byte == CH_LF) begin
          phase_nxt    = PH_TEXT;
          stat_pos_nxt = 10'd0;
          kw_flags_nxt = 3'b111;
        end else begin
          phase_nxt = PH_NONE;
          ev_valid  = 1'b1;
          ev_code   = EV_ERROR;
        end
      end else if (rx_byte == CH_CR) begin
        phase_nxt = phase_r;
      end else if (rx_byte == CH_LF) begin
        phase_nxt = PH_NONE;
        ev_valid  = 1'b1;
        if (kw_flags_r[0] && stat_pos_r >= KW_RING_LEN) begin
          ev_code  = EV_RING;
          link_nxt = 1'b1;
        end else if (kw_flags_r[1] && stat_pos_r >= KW_CONN_LEN) begin
          ev_code = EV_CONNECT;
        end else if (kw_flags_r[2] && stat_pos_r >= KW_NOCARR_LEN) begin
          ev_code  = EV_NOCARR;
          link_nxt = 1'b0;
        end else begin
          ev_code = EV_UNKNOWN;
        end
      end else if (stat_pos_r >= status_limit) begin
        ev_valid = 1'b1;
        ev_code  = EV_ERROR;
      end else begin
        if (stat_pos_r < KW_RING_LEN && rx_byte != KW_RING_TXT[stat_pos_r[2:0]]) begin
          kw_flags_nxt[0] = 1'b0;
        end
        if (stat_pos_r < KW_CONN_LEN && rx_byte != KW_CONN_TXT[stat_pos_r[2:0]]) begin
          kw_flags_nxt[1] = 1'b0;
        end
        if (stat_pos_r < KW_NOCARR_LEN && rx_byte != KW_NOCARR_TXT[stat_pos_r[3:0]]) begin
          kw_flags_nxt[2] = 1'b0;
        end
        stat_pos_nxt = stat_pos_r + 10'd1;
      end
    end else if (rx_byte == CH_CR) begin
      phase_nxt = PH_WANTLF;
    end else begin
      case (ctx_r)
        CTX_IDLE: begin
          if (rx_byte == CH_STAR || rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
            ctx_nxt       = (rx_byte == CH_STAR) ? CTX_MSG_SEQ :
                            (rx_byte == CH_PLUS) ? CTX_ACK_SEQ : CTX_NACK_SEQ;
            digit_cnt_nxt = 2'd0;
            seq_nxt       = 7'd0;
          end else begin
            ev_valid = 1'b1;
            ev_code  = EV_ERROR;
          end
        end
        CTX_MSG_SEQ, CTX_ACK_SEQ, CTX_NACK_SEQ: begin
          if (!is_digit) begin
            ctx_nxt  = CTX_IDLE;
            ev_valid = 1'b1;
            ev_code  = EV_ERROR;
          end else begin
            seq_nxt       = seq_calc;
            digit_cnt_nxt = digit_inc;
            if (digit_inc >= 2'd2) begin
              if (ctx_r == CTX_MSG_SEQ) begin
                ctx_nxt     = CTX_MSG_TEXT;
                pay_cnt_nxt = 12'd0;
              end else begin
                ctx_nxt = (ctx_r == CTX_ACK_SEQ) ? CTX_ACK_END : CTX_NACK_END;
              end
            end
          end
        end
        CTX_MSG_TEXT: begin
          if (rx_byte == CH_LF) begin
            ctx_nxt  = CTX_IDLE;
            ev_valid = 1'b1;
            ev_code  = EV_MSGEND;
          end else if (rx_byte == CH_BSL) begin
            ctx_nxt       = CTX_MSG_ESC;
            digit_cnt_nxt = 2'd0;
            hex_nxt       = 8'd0;
          end else if (rx_byte < CH_SPACE) begin
            ctx_nxt  = CTX_IDLE;
            ev_valid = 1'b1;
            ev_code  = EV_ERROR;
          end else begin
            pay_req = 1'b1;
          end
        end
        CTX_MSG_ESC: begin
          if (!hex_dec[4]) begin
            ctx_nxt  = CTX_IDLE;
            ev_valid = 1'b1;
            ev_code  = EV_ERROR;
          end else begin
            hex_nxt       = {hex_r[3:0], hex_dec[3:0]};
            digit_cnt_nxt = digit_inc;
            if (digit_inc >= 2'd2) begin
              ctx_nxt  = CTX_MSG_TEXT;
              pay_req  = 1'b1;
              pay_byte = {hex_r[3:0], hex_dec[3:0]};
            end
          end
        end
        CTX_ACK_END, CTX_NACK_END: begin
          ctx_nxt  = CTX_IDLE;
          ev_valid = 1'b1;
          if (rx_byte == CH_LF) begin
            ev_code = (ctx_r == CTX_ACK_END) ? EV_ACK : EV_NACK;
          end else begin
            ev_code = EV_ERROR;
          end
        end
        default: begin
          ctx_nxt = CTX_IDLE;
        end
      endcase

      if (pay_req) begin
        ev_valid = 1'b1;
        if (pay_cnt_r >= message_limit) begin
          ev_code = EV_ERROR;
        end else begin
          pay_cnt_nxt = pay_cnt_r + 12'd1;
          ev_code     = EV_PAYLOAD;
          ev_data     = pay_byte;
        end
      end
    end
  end

  assign res_valid          = ev_valid;
  assign res.event_res      = ev_code;
  assign res.data_byte      = ev_data;
  assign res.seq_number     = seq_nxt;
  assign res.link_connected = link_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r       <= CTX_IDLE;
      phase_r     <= PH_NONE;
      digit_cnt_r <= 2'd0;
      seq_r       <= 7'd0;
      hex_r       <= 8'd0;
      pay_cnt_r   <= 12'd0;
      stat_pos_r  <= 10'd0;
      kw_flags_r  <= 3'b111;
      link_r      <= 1'b0;
    end else if (fire) begin
      ctx_r       <= ctx_nxt;
      phase_r     <= phase_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      seq_r       <= seq_nxt;
      hex_r       <= hex_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      stat_pos_r  <= stat_pos_nxt;
      kw_flags_r  <= kw_flags_nxt;
      link_r      <= link_nxt;
    end
  end

endmodule

// ===== rtl/modem_link_stream_parser_unit.sv =====
// top level of the modem link stream parser: stream ports, limits, in/out registers
// an accepted byte goes to the input register, its event then to the output register
// throughput: one byte per cycle save out_tready stalls; core state updates only on fire
// bytes that cause no event still take one slot of the processing stage
// reset (rst_n low, synchronous) empties both registers, sets the parser idle and
// listening, and restores message_limit to 2046 and status_limit to 255
module modem_link_stream_parser_unit import mlsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [3:0] event_res, [11:4] data_byte,
                                    // [18:12] seq_number, [19] link_connected, [23:20] zero
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wr_data
);

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         out_valid_r;
  mlsp_result_t out_res_r;
  logic [11:0]  message_limit_r;
  logic [9:0]   status_limit_r;
  logic         fire;
  logic         res_valid;
  mlsp_result_t res;

  // the byte in the input register is processed when the result slot is free
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  mlsp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .rx_byte       (in_byte_r),
    .message_limit (message_limit_r),
    .status_limit  (status_limit_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      message_limit_r <= MESSAGE_LIMIT_RST;
      status_limit_r  <= STATUS_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MESSAGE_LIMIT: message_limit_r <= cfg_wr_data;
        CFG_STATUS_LIMIT:  status_limit_r  <= cfg_wr_data[9:0];
        default: begin
          message_limit_r <= message_limit_r;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.link_connected, out_res_r.seq_number,
                       out_res_r.data_byte, out_res_r.event_res};

endmodule

// ===== rtl/mlsp_checker.sv =====
// port-level checker for the modem link stream parser, bound to the top level
`include "modem_link_stream_parser_unit_assert.svh"

module mlsp_checker import mlsp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  `MLSP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // only payload events carry a data byte
  `MLSP_ASSERT_IMPL(a_data_zero, out_tvalid && (out_tdata[3:0] != EV_PAYLOAD), out_tdata[11:4] == 8'd0)

  `MLSP_ASSERT_IMPL(a_seq_range, out_tvalid, out_tdata[18:12] <= SEQ_MAX)

  // link flag follows the status events
  `MLSP_ASSERT_IMPL(a_ring_link, out_tvalid && (out_tdata[3:0] == EV_RING), out_tdata[19])

  `MLSP_ASSERT_IMPL(a_nocarr_link, out_tvalid && (out_tdata[3:0] == EV_NOCARR), !out_tdata[19])

endmodule

bind modem_link_stream_parser_unit mlsp_checker u_mlsp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata)
);

// ===== sim/modem_link_stream_parser_unit_tb.sv =====
// testbench for the modem link stream parser: framed byte stimulus, event prediction, checks
`timescale 1ns / 100ps

module modem_link_stream_parser_unit_tb;
  import mlsp_pkg::*;

  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_STALL   = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CHUNK_BYTES  = 48;

  typedef enum logic [2:0] {
    CTX_IDLE, CTX_MSG_SEQ, CTX_ACK_SEQ, CTX_NACK_SEQ,
    CTX_MSG_TEXT, CTX_MSG_ESC, CTX_ACK_END, CTX_NACK_END
  } frame_ctx_e;

  typedef enum logic [1:0] {PH_NONE, PH_WANT_LF, PH_TEXT} status_phase_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [11:0] cfg_wr_data = 12'h000;

  modem_link_stream_parser_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state as predicted
  logic [11:0]   msg_limit_q;
  logic [9:0]    stat_limit_q;
  frame_ctx_e    ctx;
  status_phase_e st_phase;
  logic [1:0]    digits;
  logic [6:0]    seq_acc;
  logic [7:0]    hex_acc;
  logic [11:0]   payload_cnt;
  logic [9:0]    st_pos;
  logic [2:0]    kw_flags;
  logic          link_up;

  logic [7:0]   rx_pending[$];
  mlsp_result_t expected_events[$];
  mlsp_result_t predicted;
  mlsp_result_t seen_event;
  mlsp_result_t want_event;

  int queued_total = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  function automatic string keyword_text(int k);
    case (k)
      0:       return "RING ";
      1:       return "CONNECT ";
      default: return "NO CARRIER";
    endcase
  endfunction

  function automatic int keyword_len(int k);
    string s;
    s = keyword_text(k);
    return s.len();
  endfunction

  function automatic logic [7:0] keyword_char(int k, int pos);
    string s;
    s = keyword_text(k);
    return s[pos];
  endfunction

  function automatic int hex_nibble(logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b) - 48;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 87;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 55;
    return -1;
  endfunction

  function automatic mlsp_result_t make_event(logic [3:0] code, logic [7:0] d);
    mlsp_result_t r;
    r.event_res      = code;
    r.data_byte      = d;
    r.seq_number     = seq_acc;
    r.link_connected = link_up;
    return r;
  endfunction

  function automatic mlsp_result_t payload_event(logic [7:0] b);
    if (payload_cnt >= msg_limit_q) return make_event(EV_ERROR, 8'h00);
    payload_cnt = payload_cnt + 12'd1;
    return make_event(EV_PAYLOAD, b);
  endfunction

  // advance the parser by one byte; returns 1 when the byte yields an event
  function automatic bit parse_byte(input logic [7:0] b, output mlsp_result_t r);
    int h;
    bit found;
    logic [3:0] code;
    r = '0;
    if (st_phase == PH_WANT_LF) begin
      if (b == CH_LF) begin
        st_phase = PH_TEXT;
        st_pos   = '0;
        kw_flags = 3'b111;
        return 1'b0;
      end
      st_phase = PH_NONE;
      r = make_event(EV_ERROR, 8'h00);
      return 1'b1;
    end
    if (st_phase == PH_TEXT) begin
      if (b == CH_CR) return 1'b0;
      if (b == CH_LF) begin
        st_phase = PH_NONE;
        found = 1'b0;
        code = EV_UNKNOWN;
        // first keyword in list order wins
        for (int k = 0; k < 3; k++) begin
          if (!found && kw_flags[k] && st_pos >= keyword_len(k)) begin
            found = 1'b1;
            code = EV_RING + 4'(k);
          end
        end
        if (code == EV_RING) link_up = 1'b1;
        if (code == EV_NOCARR) link_up = 1'b0;
        r = make_event(code, 8'h00);
        return 1'b1;
      end
      if (st_pos >= stat_limit_q) begin
        r = make_event(EV_ERROR, 8'h00);
        return 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
        if (st_pos < keyword_len(k) && b != keyword_char(k, st_pos)) kw_flags[k] = 1'b0;
      end
      st_pos = st_pos + 10'd1;
      return 1'b0;
    end
    // a status frame may open inside any other frame
    if (b == CH_CR) begin
      st_phase = PH_WANT_LF;
      return 1'b0;
    end
    case (ctx)
      CTX_IDLE: begin
        if (b == CH_STAR || b == CH_PLUS || b == CH_MINUS) begin
          if (b == CH_STAR) ctx = CTX_MSG_SEQ;
          else if (b == CH_PLUS) ctx = CTX_ACK_SEQ;
          else ctx = CTX_NACK_SEQ;
          digits  = 2'd0;
          seq_acc = 7'd0;
          return 1'b0;
        end
        r = make_event(EV_ERROR, 8'h00);
        return 1'b1;
      end
      CTX_MSG_SEQ, CTX_ACK_SEQ, CTX_NACK_SEQ: begin
        if (b < CH_ZERO || b > CH_NINE) begin
          ctx = CTX_IDLE;
          r = make_event(EV_ERROR, 8'h00);
          return 1'b1;
        end
        seq_acc = 7'(seq_acc * 7'd10 + 7'(b - CH_ZERO));
        digits = digits + 2'd1;
        if (digits >= 2'd2) begin
          if (ctx == CTX_MSG_SEQ) begin
            ctx = CTX_MSG_TEXT;
            payload_cnt = '0;
          end else if (ctx == CTX_ACK_SEQ) begin
            ctx = CTX_ACK_END;
          end else begin
            ctx = CTX_NACK_END;
          end
        end
        return 1'b0;
      end
      CTX_MSG_TEXT: begin
        if (b == CH_LF) begin
          ctx = CTX_IDLE;
          r = make_event(EV_MSGEND, 8'h00);
          return 1'b1;
        end
        if (b == CH_BSLASH) begin
          ctx = CTX_MSG_ESC;
          digits  = 2'd0;
          hex_acc = 8'h00;
          return 1'b0;
        end
        if (b < CH_SPACE) begin
          ctx = CTX_IDLE;
          r = make_event(EV_ERROR, 8'h00);
          return 1'b1;
        end
        r = payload_event(b);
        return 1'b1;
      end
      CTX_MSG_ESC: begin
        h = hex_nibble(b);
        if (h < 0) begin
          ctx = CTX_IDLE;
          r = make_event(EV_ERROR, 8'h00);
          return 1'b1;
        end
        hex_acc = {hex_acc[3:0], 4'(h)};
        digits = digits + 2'd1;
        if (digits >= 2'd2) begin
          ctx = CTX_MSG_TEXT;
          r = payload_event(hex_acc);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        code = (ctx == CTX_ACK_END) ? EV_ACK : EV_NACK;
        ctx = CTX_IDLE;
        r = make_event((b == CH_LF) ? code : EV_ERROR, 8'h00);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // stimulus building
  task automatic queue_byte(logic [7:0] b);
    rx_pending.push_back(b);
    queued_total++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(int v, bit upper);
    if (v < 10) return CH_ZERO + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_CR || b == CH_LF) b = CH_SPACE;
    return b;
  endfunction

  task automatic queue_seq();
    queue_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
    queue_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
  endtask

  task automatic queue_status();
    int pick;
    int k;
    int n;
    int cut;
    pick = $urandom_range(0, 6);
    k = $urandom_range(0, 2);
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    case (pick)
      0, 1, 2: queue_text(keyword_text(pick));
      3: begin
        // keyword cut short by one or more characters
        cut = $urandom_range(1, keyword_len(k) - 1);
        for (int i = 0; i < cut; i++) queue_byte(keyword_char(k, i));
      end
      4: begin
        cut = $urandom_range(0, keyword_len(k) - 1);
        for (int i = 0; i < keyword_len(k); i++)
          queue_byte((i == cut) ? 8'($urandom_range(8'h21, 8'h7e)) : keyword_char(k, i));
      end
      default: ;
    endcase
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    repeat (n) queue_byte(text_byte());
    if ($urandom_range(0, 3) == 0) queue_byte(CH_CR);
    queue_byte(CH_LF);
  endtask

  task automatic queue_message();
    int n;
    int pick;
    logic [7:0] b;
    queue_byte(CH_STAR);
    queue_seq();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        b = 8'($urandom_range(8'h20, 8'h7e));
        queue_byte((b == CH_BSLASH) ? 8'h61 : b);
      end else if (pick < 80) begin
        queue_byte(8'($urandom_range(8'h80, 8'hff)));
      end else if (pick < 95) begin
        queue_byte(CH_BSLASH);
        queue_byte(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
        queue_byte(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
      end else begin
        queue_status();
      end
    end
    queue_byte(CH_LF);
  endtask

  // broken frames and stray bytes
  task automatic queue_noise();
    case ($urandom_range(0, 5))
      0: queue_byte(8'($urandom_range(0, 255)));
      1: begin
        queue_byte(($urandom_range(0, 1) == 0) ? CH_STAR : CH_PLUS);
        queue_byte(8'($urandom_range(0, 255)));
      end
      2: begin
        queue_byte(CH_STAR);
        queue_seq();
        queue_byte(CH_BSLASH);
        queue_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        queue_byte(CH_STAR);
        queue_seq();
        queue_text("ok");
        queue_byte(8'($urandom_range(0, 31)));
      end
      4: begin
        queue_byte(($urandom_range(0, 1) == 0) ? CH_MINUS : CH_PLUS);
        queue_seq();
        queue_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        queue_byte(CH_CR);
        queue_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic queue_random_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      queue_message();
    end else if (r < 60) begin
      queue_byte(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
      queue_seq();
      queue_byte(CH_LF);
    end else if (r < 85) begin
      queue_status();
    end else begin
      queue_noise();
    end
  endtask

  task automatic write_limit(logic idx, logic [11:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MESSAGE_LIMIT) msg_limit_q = val;
    else stat_limit_q = val[9:0];
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (rx_pending.size() != 0 || in_tvalid || expected_events.size() != 0);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // driver: offers queued bytes, predicts on each accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (parse_byte(in_tdata, predicted)) expected_events.push_back(predicted);
      end
      if (!in_tvalid || in_tready) begin
        if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tdata  <= rx_pending.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares events in order, applies receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_event.event_res      = out_tdata[3:0];
        seen_event.data_byte      = out_tdata[11:4];
        seen_event.seq_number     = out_tdata[18:12];
        seen_event.link_connected = out_tdata[19];
        if (expected_events.size() == 0) begin
          $error("event %0d arrived with no request pending", seen_event.event_res);
          fail_count++;
        end else begin
          want_event = expected_events.pop_front();
          check_field("event_res", 8'(want_event.event_res), 8'(seen_event.event_res));
          check_field("data_byte", want_event.data_byte, seen_event.data_byte);
          check_field("seq_number", 8'(want_event.seq_number), 8'(seen_event.seq_number));
          check_field("link_connected", 8'(want_event.link_connected),
                      8'(seen_event.link_connected));
        end
      end
      if (stall_served != stall_requests) begin
        stall_served <= stall_requests;
        hold_left    <= LONG_STALL;
        out_tready   <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int phase;
    int half;
    int mark;
    msg_limit_q  = MESSAGE_LIMIT_RST;
    stat_limit_q = STATUS_LIMIT_RST;
    ctx          = CTX_IDLE;
    st_phase     = PH_NONE;
    digits       = 2'd0;
    seq_acc      = 7'd0;
    hex_acc      = 8'h00;
    payload_cnt  = '0;
    st_pos       = '0;
    kw_flags     = 3'b111;
    link_up      = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 56;
    write_limit(CFG_MESSAGE_LIMIT, 12'd1);
    write_limit(CFG_STATUS_LIMIT, 12'd10);
    @(negedge clk);

    // directed: one of each frame kind and each error path
    queue_byte(8'h00);
    queue_byte(8'hff);
    queue_text("*99\\fF");
    queue_text("A");             // over the one-byte message limit
    queue_byte(CH_LF);
    queue_text("+00");
    queue_byte(CH_LF);
    queue_text("-42x");          // bad nack ending
    queue_text("*1q");           // non-digit in sequence
    queue_text("*01");
    queue_byte(8'h01);           // control byte in text
    queue_text("*02\\g");        // bad hex escape
    queue_byte(CH_CR);
    queue_text("R");             // no LF after status CR
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    queue_text("RING");          // short line, unknown status
    queue_byte(CH_LF);
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    queue_text("NO CARRIERX");   // last byte over the status limit
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    wait_quiet();

    for (phase = 0; phase < 6; phase++) begin
      // bytes without events may still be inside the block
      repeat (DRAIN_CYCLES) @(posedge clk);
      case (phase)
        0: begin
          write_limit(CFG_MESSAGE_LIMIT, 12'd4095);
          write_limit(CFG_STATUS_LIMIT, 12'd1023);
        end
        1: begin
          write_limit(CFG_MESSAGE_LIMIT, 12'd3);
          write_limit(CFG_STATUS_LIMIT, 12'd6);
        end
        2: begin
          write_limit(CFG_MESSAGE_LIMIT, 12'd0);
          write_limit(CFG_STATUS_LIMIT, 12'd0);
        end
        3: begin
          write_limit(CFG_MESSAGE_LIMIT, 12'($urandom_range(1, 24)));
          write_limit(CFG_STATUS_LIMIT, 12'($urandom_range(1, 16)));
        end
        4: begin
          write_limit(CFG_MESSAGE_LIMIT, 12'd1);
          write_limit(CFG_STATUS_LIMIT, 12'd1);
        end
        default: begin
          write_limit(CFG_MESSAGE_LIMIT, 12'd2046);
          write_limit(CFG_STATUS_LIMIT, 12'd255);
        end
      endcase
      if (phase >= 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (phase >= 2) begin
        send_idle_pct = 56;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 15;
        recv_idle_pct = 56;
      end
      for (half = 0; half < 2; half++) begin
        @(negedge clk);
        mark = queued_total;
        while (queued_total - mark < CHUNK_BYTES) queue_random_frame();
        // receiver holds off while the sender keeps pushing
        if (phase == 0 && half == 0) stall_requests++;
        wait_quiet();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mlsp_pkg.sv
rtl/mlsp_core.sv
rtl/modem_link_stream_parser_unit.sv
rtl/mlsp_checker.sv
sim/modem_link_stream_parser_unit_tb.sv
